### sv/pfdc_pkg.sv
// Package for the PWM frequency and duty capture block.
// Holds widths, reset values, the controller state type and the
// command and status structs shared by the controller and datapath.
package pfdc_pkg;

    localparam int CNT_W_DEF = 16;
    localparam int RATE_W = 27;
    localparam logic [RATE_W-1:0] RATE_RESET = 27'd16000000;
    localparam int DUTY_W = 7;
    localparam int DUTY_SCALE = 100;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREQ,
        S_DUTY,
        S_HOLD
    } t_pfdc_state;

    typedef struct packed {
        logic fe_step;
        logic job_load;
        logic div_step;
        logic freq_store;
        logic out_load;
    } t_pfdc_cmd;

    typedef struct packed {
        logic result_event;
        logic div_last;
        logic out_free;
    } t_pfdc_sts;

endpackage

### sv/pfdc_ctrl.sv
// Controller for the PWM capture block: sequences the front end, the two
// divisions of the shared divider and the output load.
// Depends on pfdc_pkg.
module pfdc_ctrl
    import pfdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_pfdc_sts i_sts,
    output t_pfdc_cmd o_cmd
);

    t_pfdc_state r_state;
    t_pfdc_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.fe_step = 1'b1;
                    if (i_sts.result_event) begin
                        o_cmd.job_load = 1'b1;
                        n_state = S_FREQ;
                    end
                end
            end
            S_FREQ: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    // The final quotient is taken and the duty dividend loaded.
                    o_cmd.freq_store = 1'b1;
                    n_state = S_DUTY;
                end
            end
            S_DUTY: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/pfdc_datapath.sv
// Datapath for the PWM capture block: edge detection, saturating tick
// counter, a shared restoring divider and the output register.
// Depends on pfdc_pkg.
module pfdc_datapath
    import pfdc_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pin_level,
    input  logic                   i_cfg_we,
    input  logic [RATE_W-1:0]      i_cfg_data,
    input  logic                   i_out_ready,
    input  t_pfdc_cmd              i_cmd,
    output t_pfdc_sts              o_sts,
    output logic                   o_out_valid,
    output logic [COUNT_WIDTH-1:0] o_period_ticks,
    output logic [COUNT_WIDTH-1:0] o_high_ticks,
    output logic [RATE_W-1:0]      o_frequency_hz,
    output logic [DUTY_W-1:0]      o_duty_percent,
    output logic                   o_overflowed
);

    localparam int CW = COUNT_WIDTH;
    localparam int DIV_W = (RATE_W > CW + DUTY_W) ? RATE_W : CW + DUTY_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

    logic [RATE_W-1:0] r_rate;

    // Front end state.
    logic          r_prev;
    logic          r_seen;
    logic [CW-1:0] r_elapsed;
    logic [CW-1:0] r_cap;
    logic          r_sat;

    // Job and divider state.
    logic [CW-1:0]     r_per;
    logic [CW-1:0]     r_high;
    logic              r_ovf;
    logic [DIV_W-1:0]  r_num;
    logic [CW-1:0]     r_rem;
    logic [STEP_W-1:0] r_step;
    logic [RATE_W-1:0] r_freq;

    // Output register.
    logic              r_out_valid;
    logic [CW-1:0]     r_o_per;
    logic [CW-1:0]     r_o_high;
    logic [RATE_W-1:0] r_o_freq;
    logic [DUTY_W-1:0] r_o_duty;
    logic              r_o_ovf;

    logic [CW-1:0]    count;
    logic             sat_now;
    logic             sat_any;
    logic             rise;
    logic             fall;
    logic [CW-1:0]    high_clamped;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             ge;
    logic [CW-1:0]    n_rem;
    logic [DIV_W-1:0] n_num;
    logic [DIV_W-1:0] duty_dividend;

    always_comb begin
        sat_now      = (r_elapsed == CNT_MAX);
        count        = sat_now ? CNT_MAX : r_elapsed + CW'(1);
        sat_any      = r_sat | sat_now;
        rise         = !r_prev && i_pin_level;
        fall         = r_prev && !i_pin_level;
        high_clamped = (r_cap > count) ? count : r_cap;

        // One restoring division step: a quotient bit shifts in at the bottom.
        trial = {r_rem, r_num[DIV_W-1]};
        diff  = trial - {1'b0, r_per};
        ge    = (trial >= {1'b0, r_per});
        n_rem = ge ? diff[CW-1:0] : trial[CW-1:0];
        n_num = {r_num[DIV_W-2:0], ge};

        duty_dividend = DIV_W'(r_high) * DIV_W'(DUTY_SCALE);

        o_sts.result_event = rise && r_seen;
        o_sts.div_last     = (r_step == LAST_STEP);
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= 1'b0;
            r_seen    <= 1'b0;
            r_elapsed <= '0;
            r_cap     <= '0;
            r_sat     <= 1'b0;
        end else if (i_cmd.fe_step) begin
            r_prev <= i_pin_level;
            if (rise) begin
                r_seen    <= 1'b1;
                r_sat     <= 1'b0;
                r_elapsed <= '0;
            end else begin
                if (fall) begin
                    r_cap <= count;
                end
                r_elapsed <= count;
                r_sat     <= sat_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.job_load) begin
            r_per  <= count;
            r_high <= high_clamped;
            r_ovf  <= sat_any;
            r_num  <= DIV_W'(r_rate);
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.freq_store) begin
            r_freq <= n_num[RATE_W-1:0];
            r_num  <= duty_dividend;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_per  <= r_per;
            r_o_high <= r_high;
            r_o_freq <= r_freq;
            r_o_duty <= r_num[DUTY_W-1:0];
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_period_ticks = r_o_per;
    assign o_high_ticks   = r_o_high;
    assign o_frequency_hz = r_o_freq;
    assign o_duty_percent = r_o_duty;
    assign o_overflowed   = r_o_ovf;

endmodule

### sv/pwm_frequency_duty_capture_core.sv
// Top level of the PWM frequency and duty capture block.
// Joins pfdc_ctrl and pfdc_datapath; depends on pfdc_pkg.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_pin_level
// result    out        o_valid / i_ready    o_period_ticks, o_high_ticks,
//                                           o_frequency_hz, o_duty_percent,
//                                           o_overflowed
// config    in         i_cfg_we             i_cfg_data (tick rate in Hz)
//
// A sample that gives no result leaves o_ready high, so samples stream at one
// per cycle. A rising edge that gives a result holds o_ready low while the
// shared bit-serial divider forms the frequency and then the duty quotient,
// and then until the result output is free. The divider is DIV_W bits wide,
// the larger of 27 and COUNT_WIDTH+7. Reset is synchronous and needs no
// clearing pass.
module pwm_frequency_duty_capture_core
    import pfdc_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_pin_level,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [COUNT_WIDTH-1:0] o_period_ticks,
    output logic [COUNT_WIDTH-1:0] o_high_ticks,
    output logic [RATE_W-1:0]      o_frequency_hz,
    output logic [DUTY_W-1:0]      o_duty_percent,
    output logic                   o_overflowed,
    input  logic                   i_cfg_we,
    input  logic [RATE_W-1:0]      i_cfg_data
);

    t_pfdc_cmd cmd;
    t_pfdc_sts sts;

    pfdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pfdc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pin_level    (i_pin_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_valid),
        .o_period_ticks (o_period_ticks),
        .o_high_ticks   (o_high_ticks),
        .o_frequency_hz (o_frequency_hz),
        .o_duty_percent (o_duty_percent),
        .o_overflowed   (o_overflowed)
    );

endmodule

### dv/tb_top.sv
// Self-checking testbench for pwm_frequency_duty_capture_core.
// Depends on pfdc_pkg; predicts every measurement from the sampled pin levels
// and checks results in order while both handshake sides idle at random.
module tb_top;
    import pfdc_pkg::*;

    localparam int CNT_W = CNT_W_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    // Longest divider job at the default width, plus some margin.
    localparam int DRAIN_CYCLES = 2 * RATE_W + 1 + 9;
    localparam int WDOG_LIMIT = 4000;
    localparam int PHASE_SAMPLES = 310;
    localparam int PHASE_MEAS = 20;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        logic [CNT_W-1:0]  period;
        logic [CNT_W-1:0]  high;
        logic [RATE_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
        logic              ovf;
    } pwm_meas_t;

    typedef struct {
        logic      lvl;
        int        run;
        bit        chk;
        pwm_meas_t meas;
    } level_run_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_pin_level = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [CNT_W-1:0]       o_period_ticks;
    logic [CNT_W-1:0]       o_high_ticks;
    logic [RATE_W-1:0]      o_frequency_hz;
    logic [DUTY_W-1:0]      o_duty_percent;
    logic                   o_overflowed;
    logic                   i_cfg_we = 1'b0;
    logic [RATE_W-1:0]      i_cfg_data = '0;

    pwm_frequency_duty_capture_core #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_pin_level    (i_pin_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_period_ticks (o_period_ticks),
        .o_high_ticks   (o_high_ticks),
        .o_frequency_hz (o_frequency_hz),
        .o_duty_percent (o_duty_percent),
        .o_overflowed   (o_overflowed),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Capture state mirrored from the block.
    logic [RATE_W-1:0] tick_rate = RATE_RESET;
    logic              cap_prev = 1'b0;
    logic              cap_armed = 1'b0;
    logic [CNT_W-1:0]  cap_elapsed = '0;
    logic [CNT_W-1:0]  cap_high = '0;
    logic              cap_sat = 1'b0;

    pwm_meas_t   pending_meas_q[$];
    pwm_meas_t   fixed_meas[int];
    level_run_t  level_runs[$];
    int          samples_sent = 0;
    int          samples_taken = 0;
    int          meas_predicted = 0;
    int          meas_checked = 0;
    int          err_count = 0;
    int          rate_settings = 1;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          quiet_cycles = 0;

    task automatic predict_capture(input logic lvl, output bit made, output pwm_meas_t m);
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] hi;
        logic [31:0]      num;
        logic [31:0]      den;
        logic [31:0]      quo;
        begin
            made = 1'b0;
            m = '0;
            if (cap_elapsed == CNT_MAX) begin
                cnt = CNT_MAX;
                cap_sat = 1'b1;
            end else begin
                cnt = cap_elapsed + CNT_W'(1);
            end
            if (!cap_prev && lvl) begin
                if (cap_armed) begin
                    hi = (cap_high > cnt) ? cnt : cap_high;
                    den = {{(32-CNT_W){1'b0}}, cnt};
                    num = {{(32-RATE_W){1'b0}}, tick_rate};
                    quo = num / den;
                    m.freq = quo[RATE_W-1:0];
                    num = {{(32-CNT_W){1'b0}}, hi} * DUTY_SCALE;
                    quo = num / den;
                    m.duty = quo[DUTY_W-1:0];
                    m.period = cnt;
                    m.high = hi;
                    m.ovf = cap_sat;
                    made = 1'b1;
                end
                cap_armed = 1'b1;
                cap_sat = 1'b0;
                cap_elapsed = '0;
            end else begin
                if (cap_prev && !lvl)
                    cap_high = cnt;
                cap_elapsed = cnt;
            end
            cap_prev = lvl;
        end
    endtask

    task automatic log_error(input string msg);
        begin
            if (err_count < 10)
                $display("ERROR at %0t: %s", $realtime, msg);
            err_count++;
        end
    endtask

    // Result check first, then prediction of the sample taken at this edge.
    always @(posedge i_clk) begin
        pwm_meas_t got;
        pwm_meas_t want;
        pwm_meas_t calc;
        bit        made;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got.period = o_period_ticks;
                got.high = o_high_ticks;
                got.freq = o_frequency_hz;
                got.duty = o_duty_percent;
                got.ovf = o_overflowed;
                if (pending_meas_q.size() == 0) begin
                    log_error($sformatf("measurement with none pending: per %0d hi %0d f %0d d %0d o %0d",
                        got.period, got.high, got.freq, got.duty, got.ovf));
                end else begin
                    want = pending_meas_q.pop_front();
                    meas_checked++;
                    if (got !== want)
                        log_error($sformatf({"measurement mismatch: exp per %0d hi %0d f %0d d %0d o %0d,",
                            " got per %0d hi %0d f %0d d %0d o %0d"},
                            want.period, want.high, want.freq, want.duty, want.ovf,
                            got.period, got.high, got.freq, got.duty, got.ovf));
                end
            end
            if (i_valid && o_ready) begin
                predict_capture(i_pin_level, made, calc);
                if (fixed_meas.exists(samples_taken)) begin
                    if (!made)
                        log_error($sformatf("sample %0d should end a period", samples_taken));
                    else
                        calc = fixed_meas[samples_taken];
                    fixed_meas.delete(samples_taken);
                end
                if (made) begin
                    pending_meas_q.push_back(calc);
                    meas_predicted++;
                end
                samples_taken++;
            end
        end
    end

    always @(posedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("Watchdog: no transfer in %0d cycles, %0d measurements outstanding",
                    WDOG_LIMIT, pending_meas_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic lvl);
        begin
            while ($urandom_range(0, 99) < src_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_pin_level <= lvl;
            @(posedge i_clk);
            while (!o_ready)
                @(posedge i_clk);
            samples_sent++;
        end
    endtask

    task automatic send_run(input logic lvl, input int n);
        begin
            repeat (n)
                send_sample(lvl);
        end
    endtask

    task automatic wait_idle();
        begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (pending_meas_q.size() != 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES)
                @(posedge i_clk);
        end
    endtask

    task automatic write_tick_rate(input logic [RATE_W-1:0] rate);
        begin
            wait_idle();
            i_cfg_we <= 1'b1;
            i_cfg_data <= rate;
            @(posedge i_clk);
            tick_rate = rate;
            i_cfg_we <= 1'b0;
            rate_settings++;
        end
    endtask

    task automatic add_run(input logic lvl, input int run, input bit chk,
                           input int per, input int hi, input int freq, input int duty,
                           input bit ovf);
        level_run_t r;
        begin
            r.lvl = lvl;
            r.run = run;
            r.chk = chk;
            r.meas.period = CNT_W'(per);
            r.meas.high = CNT_W'(hi);
            r.meas.freq = RATE_W'(freq);
            r.meas.duty = DUTY_W'(duty);
            r.meas.ovf = ovf;
            level_runs.push_back(r);
        end
    endtask

    // One PWM cycle with random shape, or a short burst of noise.
    task automatic send_random_cycle();
        int pick;
        int per;
        int hi;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                per = (pick < 80) ? $urandom_range(2, 12) : $urandom_range(13, 300);
                hi = $urandom_range(1, per - 1);
                send_run(1'b1, hi);
                send_run(1'b0, per - hi);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_sample(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        int idle_tab[NUM_PHASES];
        int stall_tab[NUM_PHASES];
        logic [RATE_W-1:0] rate_tab[NUM_PHASES];
        int start_samples;
        int start_meas;

        idle_tab = '{0, 59, 0, 21, 0};
        stall_tab = '{0, 0, 59, 21, 0};
        rate_tab = '{27'd1, {RATE_W{1'b1}}, 27'd0, 27'd100000000, 27'd0};
        rate_tab[4] = RATE_W'($urandom_range(1, 100000000));

        repeat (9)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed runs at the reset tick rate. The level is held for a run
        // of samples; a checked row gives the measurement at its last sample.
        add_run(1'b1, 1,     0, 0, 0, 0, 0, 0);                // high at the first sample
        add_run(1'b0, 1,     0, 0, 0, 0, 0, 0);
        add_run(1'b1, 1,     1, 2, 1, 8000000, 50, 0);         // shortest period
        add_run(1'b1, 2,     0, 0, 0, 0, 0, 0);
        add_run(1'b0, 3,     0, 0, 0, 0, 0, 0);
        add_run(1'b1, 1,     0, 0, 0, 0, 0, 0);
        add_run(1'b1, 70000, 0, 0, 0, 0, 0, 0);                // counter saturates while high
        add_run(1'b0, 1,     0, 0, 0, 0, 0, 0);
        add_run(1'b1, 1,     1, 65535, 65535, 244, 100, 1);
        add_run(1'b0, 70000, 0, 0, 0, 0, 0, 0);                // counter saturates while low
        add_run(1'b1, 1,     1, 65535, 1, 244, 0, 1);
        add_run(1'b0, 1,     0, 0, 0, 0, 0, 0);
        add_run(1'b1, 1,     1, 2, 1, 8000000, 50, 0);         // flag was cleared
        add_run(1'b1, 1,     0, 0, 0, 0, 0, 0);
        add_run(1'b0, 65533, 0, 0, 0, 0, 0, 0);
        add_run(1'b1, 1,     1, 65535, 2, 244, 0, 0);          // reaches maximum, no overflow
        add_run(1'b1, 9,     0, 0, 0, 0, 0, 0);
        add_run(1'b0, 1,     0, 0, 0, 0, 0, 0);
        add_run(1'b1, 1,     0, 0, 0, 0, 0, 0);

        foreach (level_runs[k]) begin
            if (level_runs[k].run > 1)
                send_run(level_runs[k].lvl, level_runs[k].run - 1);
            if (level_runs[k].chk)
                fixed_meas[samples_sent] = level_runs[k].meas;
            send_sample(level_runs[k].lvl);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_tick_rate(rate_tab[ph]);
            src_idle_pct = idle_tab[ph];
            sink_stall_pct = stall_tab[ph];
            start_samples = samples_sent;
            start_meas = meas_predicted;
            while (samples_sent - start_samples < PHASE_SAMPLES ||
                   meas_predicted - start_meas < PHASE_MEAS)
                send_random_cycle();
        end

        wait_idle();
        $display("Sent %0d pin samples and checked %0d measurements over %0d tick rates,",
            samples_taken, meas_checked, rate_settings);
        $display("with saturation on both levels and stalls on both channels.");
        if (err_count == 0 && pending_meas_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d errors, %0d measurements outstanding", err_count,
                pending_meas_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
